// ===== rtl/prebuffered_packet_fifo_unit_macros.svh =====
// ----------------------------------------------------------------------------
// prebuffered packet fifo assertion macros
// shared property wrappers, clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef PREBUFFERED_PACKET_FIFO_UNIT_MACROS_SVH
`define PREBUFFERED_PACKET_FIFO_UNIT_MACROS_SVH

// same-cycle implication
`define PBF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbfifo_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfifo_pkg
// shared types and codes of the prebuffered packet fifo
// ----------------------------------------------------------------------------
`default_nettype none

package pbfifo_pkg;

    localparam int CMD_W    = 2;
    localparam int PKT_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int LVL_W    = 5;
    localparam int IDX_W    = 2;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PURGE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_FULL_MARK  = 2'd0;
    localparam logic [IDX_W-1:0] REG_POP_FLOOR  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LIFT_COUNT = 2'd2;
    localparam logic [IDX_W-1:0] REG_DROP_COUNT = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] FULL_MARK_RST  = 5'd10;
    localparam logic [CFG_W-1:0] POP_FLOOR_RST  = 5'd1;
    localparam logic [CFG_W-1:0] LIFT_COUNT_RST = 5'd0;
    localparam logic [CFG_W-1:0] DROP_COUNT_RST = 5'd1;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PKT_W-1:0] packet_data;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PKT_W-1:0]    packet_out;
        logic                out_valid;
        logic [LVL_W-1:0]    fill_level;
        logic [LVL_W-1:0]    dropped;
        logic                prebuffering;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic fill_pkt;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pop_ok;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/pbfifo_ram.sv =====
// ----------------------------------------------------------------------------
// pbfifo_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pbfifo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbfifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbfifo_ctrl
// request sequencing and output register occupancy
// ----------------------------------------------------------------------------
`default_nettype none

module pbfifo_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_stall,
    output logic                       rsp_valid,
    input  wire logic                  rsp_stall,
    input  wire pbfifo_pkg::dp_stat_t  stat,
    output pbfifo_pkg::ctrl_cmd_t      cmd
);

    import pbfifo_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_full_reg;
    logic   out_full_next;
    logic   slot_free;
    logic   load_now;

    // the output slot can take a result if empty or drained this cycle
    assign slot_free = !out_full_reg || !rsp_stall;
    assign rsp_valid = out_full_reg;

    always_comb
    begin
        state_next   = state_reg;
        req_stall    = 1'b1;
        cmd.accept   = 1'b0;
        cmd.fill_pkt = 1'b0;
        load_now     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall  = !slot_free;
                cmd.accept = req_valid && slot_free;
                if (cmd.accept)
                begin
                    if (stat.pop_ok)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        load_now = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // packet word lands from the store
                cmd.fill_pkt = 1'b1;
                load_now     = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (out_full_reg && !rsp_stall)
        begin
            out_full_next = 1'b0;
        end
        if (load_now)
        begin
            out_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pbfifo_dp.sv =====
// ----------------------------------------------------------------------------
// pbfifo_dp
// config registers, ring pointers, packet store and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pbfifo_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr,
    input  wire logic [pbfifo_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [pbfifo_pkg::CFG_W-1:0]        cfg_data,
    input  wire pbfifo_pkg::req_t                    req,
    input  wire pbfifo_pkg::ctrl_cmd_t               cmd,
    output pbfifo_pkg::dp_stat_t                     stat,
    output pbfifo_pkg::rsp_t                         rsp
);

    import pbfifo_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = AW + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] full_mark_reg;
    logic [CFG_W-1:0] pop_floor_reg;
    logic [CFG_W-1:0] lift_count_reg;
    logic [CFG_W-1:0] drop_count_reg;

    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             lifting_reg;
    logic             lifting_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CFG_W-1:0] mx_raw;
    logic [CMP_W-1:0] mx;
    logic [CMP_W-1:0] min_eff;
    logic [CMP_W-1:0] lift_eff;
    logic [CMP_W-1:0] drop_eff;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] drop_amt;
    logic [CMP_W-1:0] cnt_push;
    logic             full;
    logic             reject;
    logic [AW-1:0]    head_drop;
    logic [AW-1:0]    head_pop;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic             rd_en;
    logic [DATA_WIDTH-1:0] rd_data;

    function automatic logic [CMP_W-1:0] clamp(input logic [CMP_W-1:0] v,
                                               input logic [CMP_W-1:0] top);
        return (v > top) ? top : v;
    endfunction

    // ring index add, sum always below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [SUM_W-1:0] s);
        return (s >= SUM_W'(DEPTH)) ? AW'(s - SUM_W'(DEPTH)) : AW'(s);
    endfunction

    assign mx_raw   = (full_mark_reg == '0) ? CFG_W'(1) : full_mark_reg;
    assign mx       = clamp(CMP_W'(mx_raw), CMP_W'(DEPTH));
    assign min_eff  = clamp(CMP_W'(pop_floor_reg), mx);
    assign lift_eff = clamp(CMP_W'(lift_count_reg), mx);
    assign drop_eff = clamp(CMP_W'(drop_count_reg), mx);
    assign cnt_ext  = CMP_W'(count_reg);

    assign full     = cnt_ext >= mx;
    assign reject   = full && (drop_eff == '0);
    assign drop_amt = (full && !reject) ? clamp(drop_eff, cnt_ext) : '0;
    assign cnt_push = cnt_ext - drop_amt + CMP_W'(1);

    assign head_drop = wrap({1'b0, head_reg} + SUM_W'(drop_amt));
    assign head_pop  = wrap({1'b0, head_reg} + SUM_W'(1));
    // tail slot is the same before and after dropping
    assign wr_addr   = wrap({1'b0, head_reg} + SUM_W'(count_reg));

    assign stat.pop_ok = (req.cmd == CMD_POP) && !lifting_reg && (count_reg != '0)
                         && (cnt_ext >= min_eff);

    assign wr_en = cmd.accept && (req.cmd == CMD_PUSH) && !reject;
    assign rd_en = cmd.accept && stat.pop_ok;

    pbfifo_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (DATA_WIDTH'(req.packet_data)),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        head_next    = head_reg;
        count_next   = count_reg;
        lifting_next = lifting_reg;
        rsp_next     = rsp_reg;
        if (cmd.accept)
        begin
            rsp_next.status     = STATUS_OK;
            rsp_next.packet_out = '0;
            rsp_next.out_valid  = 1'b0;
            rsp_next.dropped    = '0;
            case (req.cmd)
                CMD_PUSH:
                begin
                    if (reject)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        head_next        = head_drop;
                        count_next       = CNT_W'(cnt_push);
                        rsp_next.dropped = LVL_W'(drop_amt);
                        if (lifting_reg && (cnt_push >= lift_eff))
                        begin
                            lifting_next = 1'b0;
                        end
                    end
                end
                CMD_POP:
                begin
                    if (stat.pop_ok)
                    begin
                        head_next  = head_pop;
                        count_next = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            lifting_next = 1'b1;
                        end
                    end
                    else
                    begin
                        rsp_next.status = STATUS_EMPTY;
                    end
                end
                CMD_PURGE:
                begin
                    head_next    = '0;
                    count_next   = '0;
                    lifting_next = 1'b1;
                end
                default:
                begin
                end
            endcase
            rsp_next.fill_level   = LVL_W'(count_next);
            rsp_next.prebuffering = lifting_next;
        end
        if (cmd.fill_pkt)
        begin
            rsp_next.packet_out = PKT_W'(rd_data);
            rsp_next.out_valid  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_mark_reg  <= FULL_MARK_RST;
            pop_floor_reg  <= POP_FLOOR_RST;
            lift_count_reg <= LIFT_COUNT_RST;
            drop_count_reg <= DROP_COUNT_RST;
            head_reg       <= '0;
            count_reg      <= '0;
            lifting_reg    <= 1'b1;
        end
        else
        begin
            head_reg    <= head_next;
            count_reg   <= count_next;
            lifting_reg <= lifting_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_FULL_MARK:  full_mark_reg  <= cfg_data;
                    REG_POP_FLOOR:  pop_floor_reg  <= cfg_data;
                    REG_LIFT_COUNT: lift_count_reg <= cfg_data;
                    REG_DROP_COUNT: drop_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/prebuffered_packet_fifo_unit.sv =====
// Prebuffered packet FIFO: push, pop and purge requests enter on the req channel and each
// gives exactly one result on the rsp channel. A successful pop also passes S_READ, as
// the packet store is a RAM with a registered read port and the word is fetched in the
// cycle after the request; other requests skip it. Overflow dropping only advances the
// head pointer. The result sits in an output register, so the next request is taken in
// the cycle its predecessor's result is taken. No clearing pass runs after reset; store
// words are only read after they were pushed. Configuration, always ready, goes through
// cfg_valid/cfg_index/cfg_data; write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
// prebuffered_packet_fifo_unit
// packet fifo with prebuffering phase and drop-oldest (or, with a zero drop count, reject) overflow handling
// ----------------------------------------------------------------------------
`default_nettype none

`include "prebuffered_packet_fifo_unit_macros.svh"

module prebuffered_packet_fifo_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire pbfifo_pkg::req_t              req,
    output logic                               rsp_valid,
    input  wire logic                          rsp_stall,
    output pbfifo_pkg::rsp_t                   rsp,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pbfifo_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [pbfifo_pkg::CFG_W-1:0]  cfg_data
);

    import pbfifo_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    assign cfg_ready = 1'b1;

    pbfifo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    pbfifo_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .rsp       (rsp)
    );

    // a granted pop always completes with the store word next cycle
    `PBF_ASSERT_NEXT(a_pop_fetch, ctrl_cmd.accept && dp_stat.pop_ok, ctrl_cmd.fill_pkt, "pop fetch lost")
    // fetched word never overwrites a pending result
    `PBF_ASSERT_NOW(a_fetch_slot, ctrl_cmd.fill_pkt, !rsp_valid, "fetch into occupied output")
    // a returned packet always carries ok status
    `PBF_ASSERT_NOW(a_pkt_status, rsp_valid && rsp.out_valid, rsp.status == STATUS_OK, "packet with bad status")
    // a rejected push drops nothing and returns no packet
    `PBF_ASSERT_NOW(a_reject_clean, rsp_valid && rsp.status == STATUS_FULL, rsp.dropped == '0 && !rsp.out_valid, "reject with side effects")

endmodule

`default_nettype wire
